### rtl/bol_pkg.sv
`timescale 1ns / 1ps

package bol_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_CAPACITY    = 64;
   localparam int DEF_VALUE_WIDTH = 32;

   // Fixed widths of the request and response fields.
   localparam int KIND_W     = 4;
   localparam int IN_VALUE_W = 32;
   localparam int POS_W      = 8;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 7;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // Operation kinds.
   localparam logic [KIND_W-1:0] KIND_INS_BACK   = 4'd0;
   localparam logic [KIND_W-1:0] KIND_INS_FRONT  = 4'd1;
   localparam logic [KIND_W-1:0] KIND_INS_AT     = 4'd2;
   localparam logic [KIND_W-1:0] KIND_DEL_VALUE  = 4'd3;
   localparam logic [KIND_W-1:0] KIND_DEL_FRONT  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_DEL_BACK   = 4'd5;
   localparam logic [KIND_W-1:0] KIND_DEL_AT     = 4'd6;
   localparam logic [KIND_W-1:0] KIND_READ_AT    = 4'd7;
   localparam logic [KIND_W-1:0] KIND_READ_FIRST = 4'd8;
   localparam logic [KIND_W-1:0] KIND_READ_LAST  = 4'd9;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load;
      logic                start_insert;
      logic                start_fetch;
      logic                start_search;
      logic                open_step;
      logic                close_step;
      logic                search_step;
      logic                capture;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              full;
      logic              empty;
      logic              at_gt_count;
      logic              at_ge_count;
      logic              open_done;
      logic              close_done;
      logic              found;
      logic              scan_done;
   } dp_sts_type;

endpackage

### rtl/bol_ram.sv
`timescale 1ns / 1ps

module bol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bol_ctrl.sv
`timescale 1ns / 1ps

module bol_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bol_pkg::dp_sts_type   sts,
   output bol_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_CHECK  = 7'b0000010,
      S_OPEN   = 7'b0000100,
      S_FETCH  = 7'b0001000,
      S_CLOSE  = 7'b0010000,
      S_SEARCH = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            unique case (sts.kind) inside
               bol_pkg::KIND_INS_BACK, bol_pkg::KIND_INS_FRONT, bol_pkg::KIND_INS_AT: begin
                  if (sts.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = bol_pkg::ST_FULL;
                     state_in        = S_RESP;
                  end else if (sts.at_gt_count) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = bol_pkg::ST_RANGE;
                     state_in        = S_RESP;
                  end else begin
                     cmd.start_insert = 1'b1;
                     state_in         = S_OPEN;
                  end
               end
               bol_pkg::KIND_DEL_VALUE: begin
                  if (sts.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = bol_pkg::ST_EMPTY;
                     state_in        = S_RESP;
                  end else begin
                     cmd.start_search = 1'b1;
                     state_in         = S_SEARCH;
                  end
               end
               bol_pkg::KIND_DEL_FRONT, bol_pkg::KIND_DEL_BACK, bol_pkg::KIND_DEL_AT,
               bol_pkg::KIND_READ_AT, bol_pkg::KIND_READ_FIRST,
               bol_pkg::KIND_READ_LAST: begin
                  if (sts.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = bol_pkg::ST_EMPTY;
                     state_in        = S_RESP;
                  end else if (sts.at_ge_count) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = bol_pkg::ST_RANGE;
                     state_in        = S_RESP;
                  end else begin
                     cmd.start_fetch = 1'b1;
                     state_in        = S_FETCH;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_OPEN: begin
            cmd.open_step = 1'b1;
            if (sts.open_done) begin
               state_in = S_RESP;
            end
         end
         S_FETCH: begin
            cmd.capture = 1'b1;
            if ((sts.kind == bol_pkg::KIND_DEL_FRONT) || (sts.kind == bol_pkg::KIND_DEL_BACK) ||
                (sts.kind == bol_pkg::KIND_DEL_AT)) begin
               state_in = S_CLOSE;
            end else begin
               state_in = S_RESP;
            end
         end
         S_CLOSE: begin
            cmd.close_step = 1'b1;
            if (sts.close_done) begin
               state_in = S_RESP;
            end
         end
         S_SEARCH: begin
            cmd.search_step = 1'b1;
            if (sts.found) begin
               state_in = S_CLOSE;
            end else if (sts.scan_done) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = bol_pkg::ST_NOT_FOUND;
               state_in        = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

### rtl/bol_dpath.sv
`timescale 1ns / 1ps

module bol_dpath #(
   parameter int CAPACITY    = bol_pkg::DEF_CAPACITY,
   parameter int VALUE_WIDTH = bol_pkg::DEF_VALUE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bol_pkg::ctrl_cmd_type               cmd,
   output bol_pkg::dp_sts_type                 sts,
   input  logic [bol_pkg::KIND_W-1:0]          in_kind,
   input  logic signed [bol_pkg::IN_VALUE_W-1:0] in_value,
   input  logic [bol_pkg::POS_W-1:0]           in_position,
   output logic [bol_pkg::STATUS_W-1:0]        out_status,
   output logic signed [bol_pkg::IN_VALUE_W-1:0] out_data,
   output logic [bol_pkg::COUNT_W-1:0]         out_count,
   output logic                                out_is_empty
);

   localparam int VW      = VALUE_WIDTH;
   localparam int AW      = $clog2(CAPACITY);
   localparam int CW      = $clog2(CAPACITY + 1);
   localparam int PW      = (CW > bol_pkg::POS_W) ? CW : bol_pkg::POS_W;
   localparam int OUT_VW  = bol_pkg::IN_VALUE_W;
   localparam int COUNT_W = bol_pkg::COUNT_W;

   logic [bol_pkg::KIND_W-1:0]   kind_ff;
   logic [VW-1:0]                value_ff;
   logic [bol_pkg::POS_W-1:0]    pos_ff;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                ptr_ff, ptr_in;
   logic [CW-1:0]                at_ff;
   logic [AW-1:0]                waddr_ff, waddr_in;
   logic                         wr_pend_ff, wr_pend_in;
   logic                         cmp_pend_ff, cmp_pend_in;
   logic [bol_pkg::STATUS_W-1:0] status_ff;
   logic [VW-1:0]                data_ff;

   logic [PW-1:0] at_w;
   logic [CW-1:0] ptr_next;
   logic          more_close;
   logic          more_scan;
   logic          ptr_at_target;
   logic          found;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [VW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [VW-1:0] ram_rd_data;

   // Position an operation works on, taken from its kind.
   always_comb begin
      unique case (kind_ff) inside
         bol_pkg::KIND_INS_BACK: at_w = PW'(count_ff);
         bol_pkg::KIND_INS_AT, bol_pkg::KIND_DEL_AT, bol_pkg::KIND_READ_AT: at_w = PW'(pos_ff);
         bol_pkg::KIND_DEL_BACK, bol_pkg::KIND_READ_LAST: at_w = PW'(count_ff) - PW'(1);
         default: at_w = '0;
      endcase
   end

   assign ptr_next      = ptr_ff + CW'(1);
   assign more_close    = (ptr_next < count_ff);
   assign more_scan     = (ptr_ff < count_ff);
   assign ptr_at_target = (ptr_ff == at_ff);
   assign found         = cmp_pend_ff && (ram_rd_data == value_ff);

   assign sts.kind        = kind_ff;
   assign sts.full        = (count_ff == CW'(CAPACITY));
   assign sts.empty       = (count_ff == '0);
   assign sts.at_gt_count = (at_w > PW'(count_ff));
   assign sts.at_ge_count = (at_w >= PW'(count_ff));
   assign sts.open_done   = ptr_at_target && !wr_pend_ff;
   assign sts.close_done  = !more_close && !wr_pend_ff;
   assign sts.found       = found;
   assign sts.scan_done   = !cmp_pend_ff && !more_scan;

   always_comb begin
      ptr_in      = ptr_ff;
      count_in    = count_ff;
      waddr_in    = waddr_ff;
      wr_pend_in  = 1'b0;
      cmp_pend_in = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ptr_ff[AW-1:0];
      ram_wr_en   = wr_pend_ff;
      ram_wr_addr = waddr_ff;
      ram_wr_data = ram_rd_data;

      if (cmd.start_insert) begin
         ptr_in = count_ff;
      end
      if (cmd.start_fetch) begin
         ptr_in      = CW'(at_w);
         ram_rd_en   = 1'b1;
         ram_rd_addr = at_w[AW-1:0];
      end
      if (cmd.start_search) begin
         ptr_in = '0;
      end

      // Opening a gap walks down from the end, one entry moved up a cycle.
      if (cmd.open_step) begin
         if (!ptr_at_target) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_in[AW-1:0] - AW'(1);
            wr_pend_in  = 1'b1;
            waddr_in    = ptr_ff[AW-1:0];
            ptr_in      = ptr_ff - CW'(1);
         end else if (!wr_pend_ff) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff[AW-1:0];
            ram_wr_data = value_ff;
            count_in    = count_ff + CW'(1);
         end
      end

      // Closing a gap walks up to the end, one entry moved down a cycle.
      if (cmd.close_step) begin
         if (more_close) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_next[AW-1:0];
            wr_pend_in  = 1'b1;
            waddr_in    = ptr_ff[AW-1:0];
            ptr_in      = ptr_next;
         end else if (!wr_pend_ff) begin
            count_in = count_ff - CW'(1);
         end
      end

      // The scan issues one read a cycle and compares each read in the cycle after.
      if (cmd.search_step) begin
         if (found) begin
            ptr_in = ptr_ff - CW'(1);
         end else if (more_scan) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_ff[AW-1:0];
            cmp_pend_in = 1'b1;
            ptr_in      = ptr_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         wr_pend_ff  <= 1'b0;
         cmp_pend_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         wr_pend_ff  <= wr_pend_in;
         cmp_pend_ff <= cmp_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      waddr_ff <= waddr_in;
      if (cmd.load) begin
         kind_ff   <= in_kind;
         value_ff  <= VW'(in_value);
         pos_ff    <= in_position;
         status_ff <= bol_pkg::ST_OK;
         data_ff   <= '0;
      end
      if (cmd.start_insert) begin
         at_ff <= CW'(at_w);
      end
      if (cmd.capture) begin
         data_ff <= ram_rd_data;
      end
      if (cmd.search_step && found) begin
         data_ff <= value_ff;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end
   end

   bol_ram #(
      .WIDTH (VW),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_status   = status_ff;
   assign out_data     = OUT_VW'(signed'(data_ff));
   assign out_count    = COUNT_W'(count_ff);
   assign out_is_empty = (count_ff == '0);

endmodule

### rtl/bounded_ordered_list_unit.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed values, held in a single-port-write,
// registered-read store together with an entry count. Each request carries an
// operation kind on req_tuser and a value and position on req_tdata; each one
// produces exactly one response giving the status, the value read or removed,
// the count afterwards and an empty flag. Requests are handled one at a time:
// req_tready is high only while the unit is idle, and a response waits in its
// output registers until rsp_tready takes it. After acceptance and a check
// state, a read fetches its entry; an insert moves entries up one per cycle
// through the store from the end down to its position; a positional delete,
// front and back included, fetches its entry and moves the entries behind it
// down one per cycle; a delete by value scans, one entry read a cycle, up to
// the first match, and the gap then closes over the entries behind it. Errors
// (full, empty, bad position) answer straight after the check. The store
// takes one write and one read per cycle. No clearing pass follows reset:
// only entries below the count are ever read.
module bounded_ordered_list_unit #(
   parameter int CAPACITY    = bol_pkg::DEF_CAPACITY,
   parameter int VALUE_WIDTH = bol_pkg::DEF_VALUE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // value [31:0], position [39:32]
   input  logic [bol_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind [3:0]
   input  logic [bol_pkg::KIND_W-1:0]       req_tuser,
   // Response channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // data_out [31:0], count [38:32], is_empty [39]
   output logic [bol_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status [2:0]
   output logic [bol_pkg::STATUS_W-1:0]     rsp_tuser
);

   bol_pkg::ctrl_cmd_type cmd;
   bol_pkg::dp_sts_type   sts;

   logic [bol_pkg::STATUS_W-1:0]          rsp_status;
   logic signed [bol_pkg::IN_VALUE_W-1:0] rsp_data;
   logic [bol_pkg::COUNT_W-1:0]           rsp_count;
   logic                                  rsp_is_empty;

   // The controller sequences each request; the datapath owns the store,
   // the count, the walking pointer and the response registers.
   bol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bol_dpath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .in_kind      (req_tuser),
      .in_value     (req_tdata[31:0]),
      .in_position  (req_tdata[39:32]),
      .out_status   (rsp_status),
      .out_data     (rsp_data),
      .out_count    (rsp_count),
      .out_is_empty (rsp_is_empty)
   );

   assign rsp_tdata = {rsp_is_empty, rsp_count, rsp_data};
   assign rsp_tuser = rsp_status;

   // Only one request is ever in flight, so the unit never offers to take a
   // new request while a response is still on offer.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   // The response always follows its request by at least the check cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("response offered in the cycle after acceptance");

   // A failed request reports no data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != bol_pkg::ST_OK)) |-> (rsp_tdata[31:0] == '0))
      else $error("data present on a failed request");

   // An empty status leaves the list empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == bol_pkg::ST_EMPTY)) |-> rsp_tdata[39])
      else $error("empty status reported on a list that holds entries");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import bol_pkg::*;

   localparam int CAP = DEF_CAPACITY;

   // Kinds that the unit treats as no operation.
   localparam logic [KIND_W-1:0] KIND_UNUSED_LOW = KIND_READ_LAST + 4'd1;
   localparam logic [KIND_W-1:0] KIND_UNUSED_TOP = '1;

   localparam int RANDOM_REQUESTS = 850;
   localparam int SEGMENT         = 125;

   // One response of the unit, split into its fields.
   typedef struct {
      logic [STATUS_W-1:0]   status;
      logic [IN_VALUE_W-1:0] data;
      logic [COUNT_W-1:0]    count;
      logic                  is_empty;
   } list_result_type;

   // Keeps its own copy of the list, works out the response to every request
   // as it is accepted, and compares the responses of the unit against those
   // in order of arrival.
   class list_scoreboard;
      logic [IN_VALUE_W-1:0] store [CAP];
      int                    count;
      int                    peak;
      list_result_type       expected_q [$];
      int                    status_hits [5];
      int                    requests;
      int                    responses;
      int                    errors;

      function automatic logic [IN_VALUE_W-1:0] remove_at(int at);
         logic [IN_VALUE_W-1:0] v;
         v = store[at];
         for (int i = at; i + 1 < count; i++) store[i] = store[i + 1];
         count--;
         return v;
      endfunction

      function automatic void note_request(logic [KIND_W-1:0] kind,
                                           logic [IN_VALUE_W-1:0] value,
                                           logic [POS_W-1:0] pos);
         list_result_type r;
         int              at;
         bit              full;
         bit              empty;
         r.status = ST_OK;
         r.data   = '0;
         full     = count >= CAP;
         empty    = count == 0;
         case (kind)
            KIND_INS_BACK, KIND_INS_FRONT, KIND_INS_AT: begin
               if (full) begin
                  r.status = ST_FULL;
               end else begin
                  at = (kind == KIND_INS_BACK) ? count : (kind == KIND_INS_FRONT) ? 0 : int'(pos);
                  if (at > count) begin
                     r.status = ST_RANGE;
                  end else begin
                     for (int i = count; i > at; i--) store[i] = store[i - 1];
                     store[at] = value;
                     count++;
                  end
               end
            end
            KIND_DEL_VALUE: begin
               if (empty) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.status = ST_NOT_FOUND;
                  for (int i = 0; i < count; i++) begin
                     if (store[i] == value) begin
                        r.data   = remove_at(i);
                        r.status = ST_OK;
                        break;
                     end
                  end
               end
            end
            KIND_DEL_FRONT: begin
               if (empty) r.status = ST_EMPTY;
               else r.data = remove_at(0);
            end
            KIND_DEL_BACK: begin
               if (empty) r.status = ST_EMPTY;
               else r.data = remove_at(count - 1);
            end
            KIND_DEL_AT: begin
               if (empty) r.status = ST_EMPTY;
               else if (int'(pos) >= count) r.status = ST_RANGE;
               else r.data = remove_at(int'(pos));
            end
            KIND_READ_AT: begin
               if (empty) r.status = ST_EMPTY;
               else if (int'(pos) >= count) r.status = ST_RANGE;
               else r.data = store[int'(pos)];
            end
            KIND_READ_FIRST: begin
               if (empty) r.status = ST_EMPTY;
               else r.data = store[0];
            end
            KIND_READ_LAST: begin
               if (empty) r.status = ST_EMPTY;
               else r.data = store[count - 1];
            end
            default: ;
         endcase
         if (r.status != ST_OK) r.data = '0;
         r.count    = count[COUNT_W-1:0];
         r.is_empty = (count == 0);
         if (count > peak) peak = count;
         status_hits[r.status]++;
         requests++;
         expected_q.push_back(r);
      endfunction

      function automatic void check_response(logic [STATUS_W-1:0] status,
                                             logic [IN_VALUE_W-1:0] data,
                                             logic [COUNT_W-1:0] cnt,
                                             logic is_empty);
         list_result_type e;
         responses++;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding: status %0d, data %0d",
                   status, $signed(data));
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            errors++;
         end
         if (data !== e.data) begin
            $error("data_out: expected %0d, actual %0d", $signed(e.data), $signed(data));
            errors++;
         end
         if (cnt !== e.count) begin
            $error("count: expected %0d, actual %0d", e.count, cnt);
            errors++;
         end
         if (is_empty !== e.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", e.is_empty, is_empty);
            errors++;
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // value [31:0], position [39:32]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // kind [3:0]
   logic [KIND_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // data_out [31:0], count [38:32], is_empty [39]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // status [2:0]
   logic [STATUS_W-1:0]   rsp_tuser;

   // When set, neither side idles nor stalls.
   logic steady = 1'b0;

   list_scoreboard sb = new();

   bounded_ordered_list_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls in roughly a third of all cycles, except during the
   // steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 35);
   end

   // Every response taken at a rising edge is checked against the oldest
   // outstanding expectation. Values are sampled as they stood at the edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata[31:0], rsp_tdata[38:32], rsp_tdata[39]);
   end

   // Offers one request and waits until the unit takes it. The sender may
   // idle first for a random number of cycles, with valid held low. Valid is
   // left high afterwards, so that back-to-back requests need no second
   // assignment in the same time step.
   task automatic send_request(logic [KIND_W-1:0] kind, logic [IN_VALUE_W-1:0] value,
                               logic [POS_W-1:0] pos);
      while (!steady && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pos, value};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, value, pos);
   endtask

   // Values lean towards a small pool, so that duplicates arise and a delete
   // by value has to pick the first match, and towards the two extremes.
   function automatic logic [IN_VALUE_W-1:0] pick_value();
      int r;
      int v;
      r = $urandom_range(99);
      if (r < 25) begin
         v = int'($urandom_range(7)) - 4;
         return v;
      end
      if (r < 32) return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return $urandom;
   endfunction

   // One random request. insert_pct steers the mix so that the list fills up
   // to capacity in some segments and drains to empty in others. Deletes by
   // value mostly name an entry that is present; positions are mostly valid,
   // and now and then anything the field can hold.
   task automatic random_request(int insert_pct);
      logic [KIND_W-1:0]     kind;
      logic [IN_VALUE_W-1:0] value;
      logic [POS_W-1:0]      pos;
      int                    n;
      int                    r;
      n = sb.count;
      r = $urandom_range(99);
      if (r < 3)
         kind = KIND_W'($urandom_range(KIND_UNUSED_TOP, KIND_UNUSED_LOW));
      else if (r < 3 + insert_pct * 97 / 100)
         kind = KIND_W'($urandom_range(KIND_INS_AT, KIND_INS_BACK));
      else if ($urandom_range(99) < 60)
         kind = KIND_W'($urandom_range(KIND_DEL_AT, KIND_DEL_VALUE));
      else
         kind = KIND_W'($urandom_range(KIND_READ_LAST, KIND_READ_AT));
      value = pick_value();
      if (kind == KIND_DEL_VALUE && n > 0 && $urandom_range(99) < 75)
         value = sb.store[$urandom_range(n - 1)];
      if ($urandom_range(99) < 15)
         pos = POS_W'($urandom);
      else if (kind == KIND_INS_AT)
         pos = POS_W'($urandom_range(n));
      else
         pos = (n > 0) ? POS_W'($urandom_range(n - 1)) : '0;
      send_request(kind, value, pos);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. An empty list must refuse every delete and read, and
      // an insert beyond the count; unused kinds do nothing.
      send_request(KIND_READ_FIRST, '0, '0);
      send_request(KIND_READ_LAST, '0, '0);
      send_request(KIND_READ_AT, '0, '0);
      send_request(KIND_DEL_FRONT, '0, '0);
      send_request(KIND_DEL_BACK, '0, '0);
      send_request(KIND_DEL_AT, '0, '0);
      send_request(KIND_DEL_VALUE, '0, '0);
      send_request(KIND_INS_AT, 32'd5, 8'd1);
      send_request(KIND_UNUSED_LOW, 32'hFFFF_FFFF, 8'd255);
      send_request(KIND_UNUSED_TOP, '0, '0);
      // Build the list min, -1, max, 0 with every insert flavour.
      send_request(KIND_INS_BACK, 32'h7FFF_FFFF, '0);
      send_request(KIND_INS_FRONT, 32'h8000_0000, '0);
      send_request(KIND_INS_AT, 32'hFFFF_FFFF, 8'd1);
      send_request(KIND_INS_AT, '0, 8'd3);
      send_request(KIND_INS_AT, 32'd9, 8'd255);
      // Reads, good and out of range.
      send_request(KIND_READ_AT, '0, 8'd2);
      send_request(KIND_READ_AT, '0, 8'd4);
      send_request(KIND_READ_AT, '0, 8'd255);
      send_request(KIND_READ_FIRST, '0, '0);
      send_request(KIND_READ_LAST, '0, '0);
      // Deletes of every flavour, down to empty again.
      send_request(KIND_DEL_VALUE, 32'd12345, '0);
      send_request(KIND_DEL_VALUE, 32'hFFFF_FFFF, '0);
      send_request(KIND_DEL_AT, '0, 8'd3);
      send_request(KIND_DEL_AT, '0, 8'd1);
      send_request(KIND_DEL_FRONT, '0, '0);
      send_request(KIND_DEL_BACK, '0, '0);

      // Random part in segments: fill, drain, mixed, mixed, and so on. One
      // segment of the mixed traffic runs with no idling on either side.
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == 3 * SEGMENT) steady <= 1'b1;
         if (i == 4 * SEGMENT) steady <= 1'b0;
         case ((i / SEGMENT) % 4)
            0:       random_request(85);
            1:       random_request(15);
            default: random_request(50);
         endcase
      end
      req_tvalid <= 1'b0;

      // Drain the outstanding responses, then allow for the longest request
      // to finish so that any stray response is still caught.
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses; the list reached %0d entries.",
               sb.requests, sb.responses, sb.peak);
      $display("Refusals seen: full %0d, empty %0d, bad position %0d, value absent %0d.",
               sb.status_hits[ST_FULL], sb.status_hits[ST_EMPTY],
               sb.status_hits[ST_RANGE], sb.status_hits[ST_NOT_FOUND]);
      if (sb.errors == 0) begin
         $display("bounded_ordered_list_unit: match");
      end else begin
         $display("bounded_ordered_list_unit: mismatch");
      end
      $finish;
   end

   // Safety net: a hung handshake ends the run here.
   initial begin
      #10_000_000;
      $error("timeout with %0d responses outstanding", sb.expected_q.size());
      $display("bounded_ordered_list_unit: mismatch");
      $finish;
   end

endmodule
